@@ src/ffha_pkg.sv @@
package ffha_pkg;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam int unsigned SIZE_LIMIT = 1020;

endpackage

@@ src/first_fit_heap_allocator.sv @@
// steps: each free-table entry scanned or shifted passes a read, a wait and a check
//   or write state; the table ram has one read port and one write port
// throughput: one item at a time; busy is high from start until the result strobe
// reset: synchronous, clears the entry count and sets clean region and free bytes
//   to the heap size; the table ram needs no clearing pass
// the receiver cannot stall: the result is valid for the one cycle done is high
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES      = 4096,
  parameter int unsigned MAX_FREE_BLOCKS = 64,
  parameter int unsigned MIN_CHUNK       = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [9:0]  req_size,
  input  logic [11:0] chunk_addr,
  input  logic [12:0] chunk_size,
  output logic        done,
  output logic [1:0]  status,
  output logic [11:0] grant_addr,
  output logic [12:0] grant_size,
  output logic [12:0] avail_bytes
);

  localparam int unsigned AW = $clog2(MAX_FREE_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_FREE_BLOCKS + 1);
  localparam int unsigned DW = 25;
  localparam logic [13:0] HEAP = 14'(HEAP_BYTES);
  localparam logic [13:0] SPLIT = 14'(2 * MIN_CHUNK);
  localparam logic [CW-1:0] MAXC = CW'(MAX_FREE_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_ARD, S_AWAIT, S_ACHK, S_FRD, S_FWAIT, S_FCMP, S_FCHK,
    S_DRD, S_DWAIT, S_DWR, S_IRD, S_IWAIT, S_IWR, S_DONE
  } state_t;

  state_t state;
  logic [CW-1:0] count, idx, last;
  logic [13:0] clean_ptr, clean_left, bytes_free;
  logic [13:0] need, a_addr, a_len;
  logic [11:0] prev_s;
  logic [13:0] prev_l;
  logic has_prev;
  logic [11:0] hold_s;
  logic [12:0] hold_l;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [11:0] r_s;
  logic [13:0] r_l;

  ffha_ram #(.WIDTH(DW), .DEPTH(MAX_FREE_BLOCKS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign r_s = rdata[24:13];
  assign r_l = {1'b0, rdata[12:0]};
  assign busy = state != S_IDLE;

  function automatic logic [13:0] sat(input logic [13:0] a, input logic [13:0] b);
    logic [14:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, HEAP}) ? HEAP : s[13:0];
  endfunction

  logic [13:0] req_c;
  always_comb begin
    req_c = (14'(req_size) < 14'(MIN_CHUNK)) ? 14'(MIN_CHUNK) : 14'(req_size);
    req_c = (req_c + 14'd3) & ~14'd3;
  end

  logic [13:0] prev_end, f_end;
  assign prev_end = 14'(prev_s) + prev_l;
  assign f_end = a_addr + a_len;

  always_ff @(posedge clk) begin
    we <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      clean_ptr <= '0;
      clean_left <= HEAP;
      bytes_free <= HEAP;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            idx <= '0;
            has_prev <= 1'b0;
            grant_addr <= '0;
            grant_size <= '0;
            status <= ffha_pkg::ST_OK;
            need <= req_c;
            a_addr <= 14'(chunk_addr);
            a_len <= 14'(chunk_size);
            if (opcode == ffha_pkg::OP_ALLOC) begin
              if (14'(req_size) > 14'(ffha_pkg::SIZE_LIMIT)) begin
                status <= ffha_pkg::ST_FAIL;
                state <= S_DONE;
              end else begin
                state <= S_ARD;
              end
            end else if (chunk_size == '0 ||
                         15'(chunk_addr) + 15'(chunk_size) > 15'(HEAP_BYTES)) begin
              status <= ffha_pkg::ST_FAIL;
              state <= S_DONE;
            end else begin
              state <= S_FRD;
            end
          end
        end
        S_ARD: begin
          if (idx < count) begin
            raddr <= idx[AW-1:0];
            state <= S_AWAIT;
          end else if (clean_left >= need) begin
            grant_addr <= clean_ptr[11:0];
            grant_size <= need[12:0];
            clean_ptr <= clean_ptr + need;
            clean_left <= clean_left - need;
            bytes_free <= (bytes_free > need) ? bytes_free - need : '0;
            state <= S_DONE;
          end else begin
            status <= ffha_pkg::ST_FAIL;
            state <= S_DONE;
          end
        end
        S_AWAIT: state <= S_ACHK;
        S_ACHK: begin
          if (r_l >= need) begin
            grant_addr <= r_s;
            if (r_l >= need + SPLIT) begin
              grant_size <= need[12:0];
              bytes_free <= (bytes_free > need) ? bytes_free - need : '0;
              we <= 1'b1;
              waddr <= idx[AW-1:0];
              wdata <= {r_s + need[11:0], 13'(r_l - need)};
              state <= S_DONE;
            end else begin
              grant_size <= r_l[12:0];
              bytes_free <= (bytes_free > r_l) ? bytes_free - r_l : '0;
              last <= count - 1'b1;
              count <= count - 1'b1;
              state <= S_DRD;
            end
          end else begin
            idx <= idx + 1'b1;
            state <= S_ARD;
          end
        end
        S_FRD: begin
          if (idx < count) begin
            raddr <= idx[AW-1:0];
            state <= S_FWAIT;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FWAIT: state <= S_FCMP;
        S_FCMP: begin
          if (14'(r_s) < a_addr) begin
            prev_s <= r_s;
            prev_l <= r_l;
            has_prev <= 1'b1;
            idx <= idx + 1'b1;
            state <= S_FRD;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          // idx = insertion point p; rdata holds entry p when idx < count
          if (has_prev && prev_end == a_addr) begin
            if (idx < count && 14'(sat(prev_l, a_len)) + 14'(prev_s) == 14'(r_s)) begin
              we <= 1'b1;
              waddr <= AW'(idx - 1'b1);
              wdata <= {prev_s, 13'(sat(sat(prev_l, a_len), r_l))};
              last <= count - 1'b1;
              count <= count - 1'b1;
              state <= S_DRD;
            end else begin
              we <= 1'b1;
              waddr <= AW'(idx - 1'b1);
              wdata <= {prev_s, 13'(sat(prev_l, a_len))};
              state <= S_DONE;
            end
            bytes_free <= sat(bytes_free, a_len);
          end else if (idx < count && f_end == 14'(r_s)) begin
            we <= 1'b1;
            waddr <= idx[AW-1:0];
            wdata <= {a_addr[11:0], 13'(sat(r_l, a_len))};
            bytes_free <= sat(bytes_free, a_len);
            state <= S_DONE;
          end else if (count >= MAXC) begin
            status <= ffha_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            bytes_free <= sat(bytes_free, a_len);
            hold_s <= a_addr[11:0];
            hold_l <= a_len[12:0];
            count <= count + 1'b1;
            state <= S_IRD;
          end
        end
        // shift entries idx+1..last down by one
        S_DRD: begin
          if (idx < last) begin
            raddr <= AW'(idx + 1'b1);
            state <= S_DWAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_DWAIT: state <= S_DWR;
        S_DWR: begin
          we <= 1'b1;
          waddr <= idx[AW-1:0];
          wdata <= rdata;
          idx <= idx + 1'b1;
          state <= S_DRD;
        end
        // insert by rippling: read entry idx, write held value, hold old
        S_IRD: begin
          if (idx + 1'b1 < count) begin
            raddr <= idx[AW-1:0];
            state <= S_IWAIT;
          end else begin
            we <= 1'b1;
            waddr <= idx[AW-1:0];
            wdata <= {hold_s, hold_l};
            state <= S_DONE;
          end
        end
        S_IWAIT: state <= S_IWR;
        S_IWR: begin
          we <= 1'b1;
          waddr <= idx[AW-1:0];
          wdata <= {hold_s, hold_l};
          hold_s <= r_s;
          hold_l <= r_l[12:0];
          idx <= idx + 1'b1;
          state <= S_IRD;
        end
        S_DONE: begin
          done <= 1'b1;
          avail_bytes <= bytes_free[12:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  assert property (@(posedge clk) disable iff (rst) count <= MAXC)
    else $error("free table overflow");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("transfer not taken");
  assert property (@(posedge clk) disable iff (rst) bytes_free <= HEAP)
    else $error("free bytes above heap size");

endmodule

@@ src/ffha_ram.sv @@
module ffha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
